@@ src/sbce_pkg.sv @@
`default_nettype none
package sbce_pkg;

  localparam int unsigned WordW   = 6;
  localparam int unsigned InstrW  = 24;
  localparam int unsigned OpGroup = 21;
  localparam int unsigned MulFrac = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [2:0]       status_t;
  typedef logic [4:0]       op_t;

  // result status codes
  localparam status_t StOk     = 3'd0;
  localparam status_t StSkip   = 3'd1;
  localparam status_t StHalt   = 3'd2;
  localparam status_t StError  = 3'd3;
  localparam status_t StJmpUp  = 3'd4;
  localparam status_t StJmpDn  = 3'd5;
  localparam status_t StIoReq  = 3'd6;

  // operation codes inside a condition group
  localparam op_t OpAddR  = 5'd0;
  localparam op_t OpAddI  = 5'd1;
  localparam op_t OpSubR  = 5'd2;
  localparam op_t OpCmp   = 5'd3;
  localparam op_t OpOrR   = 5'd4;
  localparam op_t OpOrI   = 5'd5;
  localparam op_t OpXorR  = 5'd6;
  localparam op_t OpXorI  = 5'd7;
  localparam op_t OpAndR  = 5'd8;
  localparam op_t OpAndI  = 5'd9;
  localparam op_t OpShImm = 5'd10;
  localparam op_t OpShlR  = 5'd11;
  localparam op_t OpShrR  = 5'd12;
  localparam op_t OpLoad  = 5'd13;
  localparam op_t OpStore = 5'd14;
  localparam op_t OpLabel = 5'd15;
  localparam op_t OpJmpUp = 5'd16;
  localparam op_t OpJmpDn = 5'd17;
  localparam op_t OpIo    = 5'd18;
  localparam op_t OpMul   = 5'd19;

  // condition groups
  localparam logic [1:0] GrpAlways = 2'd0;
  localparam logic [1:0] GrpIfSet  = 2'd1;
  localparam logic [1:0] GrpIfClr  = 2'd2;

endpackage
`default_nettype wire

@@ src/sbce_in_if.sv @@
`default_nettype none
interface sbce_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [sbce_pkg::InstrW-1:0]       instr_word;
  logic [sbce_pkg::WordW-1:0]        return_reg;
  logic [sbce_pkg::WordW-1:0]        return_data;

  modport source (output valid, kind, instr_word, return_reg, return_data, input ready);
  modport sink (input valid, kind, instr_word, return_reg, return_data, output ready);
endinterface
`default_nettype wire

@@ src/sbce_out_if.sv @@
`default_nettype none
interface sbce_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic                       flag_out;
  logic [11:0]                jump_label;
  logic [sbce_pkg::WordW-1:0] jump_key;
  logic [sbce_pkg::WordW-1:0] io_device;
  logic [sbce_pkg::WordW-1:0] io_write_data;
  logic [sbce_pkg::WordW-1:0] io_dest_reg;
  logic                       io_wants_read;

  modport source (output valid, status, flag_out, jump_label, jump_key, io_device,
                  io_write_data, io_dest_reg, io_wants_read, input ready);
  modport sink (input valid, status, flag_out, jump_label, jump_key, io_device,
                io_write_data, io_dest_reg, io_wants_read, output ready);
endinterface
`default_nettype wire

@@ src/six_bit_cpu_execute_unit.sv @@
// Pipeline: a word is accepted into stage 1 together with its register reads, and the
// result word goes into the output register when stage 1 fires.
// Throughput: one word per cycle unless the output stalls; a register-indirect load
// holds stage 1 for a second read, as its address comes out of the first read of the register file copies.
// Reset (synchronous, active low) clears the flag, the pipeline and the entry
// valid bits, so every register reads zero until it is written.
`default_nettype none
module six_bit_cpu_execute_unit (
  input  wire         clk,
  input  wire         rst_n,
  sbce_in_if.sink     in_ch,
  sbce_out_if.source  out_ch
);

  localparam int unsigned W = sbce_pkg::WordW;

  // two copies of the register file give two read ports
  logic [W-1:0] mem_p_r [64];
  logic [W-1:0] mem_q_r [64];
  logic [63:0]  ent_vld_r;

  logic [W-1:0] raw_p_r, raw_q_r, fwd_p_r, fwd_q_r;
  logic         zero_p_r, zero_q_r, use_p_r, use_q_r;

  logic                        s1_vld_r, s1_ph_r, flag_r;
  logic                        s1_kind_r;
  logic [sbce_pkg::InstrW-1:0] s1_word_r;
  logic [W-1:0]                s1_rreg_r, s1_rdat_r;

  logic                out_vld_r;
  logic [2:0]          o_status_r;
  logic                o_flag_r, o_wants_r;
  logic [11:0]         o_label_r;
  logic [W-1:0]        o_key_r, o_dev_r, o_wdat_r, o_dest_r;

  // stage 1 decode
  logic [W-1:0]       opc, fa, fb, fc, opm1;
  logic [1:0]         grp;
  sbce_pkg::op_t      op;
  logic               pass, ab_ports, ld_wait, s1_fire, in_acc, rd_en;
  logic [W-1:0]       va, vb, ra, rb, rc, x, y;
  logic               wr_en;
  logic [W-1:0]       wr_addr, wr_data;
  logic [2:0]         st;
  logic               flag_nxt, wants;
  logic [11:0]        label;
  logic [W-1:0]       key, dev, wdat, dest;
  logic [W-1:0]       ld_addr, addr_p, addr_q;
  logic               dev_ok, dev_rd;
  logic [2:0]         sh;
  logic [11:0]        uprod;
  logic signed [12:0] sprod;
  logic [4:0]         samt;
  logic [W-1:0]       sres;

  // input side decode for read port selection
  logic [W-1:0]  i_opc, i_m1;
  sbce_pkg::op_t i_op;

  function automatic sbce_pkg::op_t op_of(input logic [W-1:0] m1);
    if (m1 < W'(sbce_pkg::OpGroup)) return sbce_pkg::op_t'(m1);
    else if (m1 < W'(2*sbce_pkg::OpGroup)) return sbce_pkg::op_t'(m1 - W'(sbce_pkg::OpGroup));
    else return sbce_pkg::op_t'(m1 - W'(2*sbce_pkg::OpGroup));
  endfunction

  always_comb begin
    i_opc = in_ch.instr_word[23:18];
    i_m1  = i_opc - W'(1);
    i_op  = op_of(i_m1);
  end

  // stage 1 operand values
  assign va = zero_p_r ? '0 : (use_p_r ? fwd_p_r : raw_p_r);
  assign vb = zero_q_r ? '0 : (use_q_r ? fwd_q_r : raw_q_r);

  always_comb begin
    opc  = s1_word_r[23:18];
    fa   = s1_word_r[17:12];
    fb   = s1_word_r[11:6];
    fc   = s1_word_r[5:0];
    opm1 = opc - W'(1);
    op   = op_of(opm1);
    if (opm1 < W'(sbce_pkg::OpGroup)) grp = sbce_pkg::GrpAlways;
    else if (opm1 < W'(2*sbce_pkg::OpGroup)) grp = sbce_pkg::GrpIfSet;
    else grp = sbce_pkg::GrpIfClr;
    pass = !((grp == sbce_pkg::GrpIfSet && !flag_r) || (grp == sbce_pkg::GrpIfClr && flag_r));
    ab_ports = (op == sbce_pkg::OpStore) || (op == sbce_pkg::OpMul);
    ra = va;
    rb = ab_ports ? vb : va;
    rc = vb;
    ld_addr = rb + fc;

    dev_ok = (fb <= W'(4)) || (fb >= W'(16) && fb <= W'(23)) || (fb == W'(34));
    dev_rd = (fb == W'(0)) || (fb == W'(1)) || (fb == W'(3)) || (fb == W'(4)) ||
             (fb == W'(19)) || (fb == W'(34));

    // multiply
    uprod = {6'd0, ra} * {6'd0, rb};
    sprod = 13'(signed'(ra)) * 13'(signed'(rb));
    samt  = (fc - W'(sbce_pkg::MulFrac) > W'(31)) ? 5'd31 : 5'(fc - W'(sbce_pkg::MulFrac));

    // immediate shift or rotate
    sh = fc[2:0];
    case (fc[4:3])
      2'd0: sres = (sh >= 3'd6) ? '0 : W'(rb << sh);
      2'd1: sres = (sh >= 3'd6) ? '0 : W'(rb >> sh);
      2'd2: sres = W'($signed(rb) >>> sh);
      default: begin
        case (sh)
          3'd1, 3'd7: sres = {rb[4:0], rb[5]};
          3'd2: sres = {rb[3:0], rb[5:4]};
          3'd3: sres = {rb[2:0], rb[5:3]};
          3'd4: sres = {rb[1:0], rb[5:2]};
          3'd5: sres = {rb[0], rb[5:1]};
          default: sres = rb;
        endcase
      end
    endcase

    // compare operands
    if (fa < W'(8)) begin
      x = rb; y = rc;
    end else if (fa < W'(16)) begin
      x = rc; y = rb;
    end else if (fa < W'(24)) begin
      x = rb; y = fc;
    end else begin
      x = fb; y = rc;
    end

    st = sbce_pkg::StOk;
    flag_nxt = flag_r;
    wr_en = 1'b0;
    wr_addr = fa;
    wr_data = '0;
    label = '0; key = '0; dev = '0; wdat = '0; dest = '0; wants = 1'b0;
    ld_wait = 1'b0;

    if (s1_kind_r) begin
      wr_en = 1'b1;
      wr_addr = s1_rreg_r;
      wr_data = s1_rdat_r;
    end else if (opc == '0) begin
      st = sbce_pkg::StHalt;
    end else if (!pass) begin
      st = sbce_pkg::StSkip;
    end else begin
      case (op)
        sbce_pkg::OpAddR: begin wr_en = 1'b1; wr_data = rb + rc; end
        sbce_pkg::OpAddI: begin wr_en = 1'b1; wr_data = rb + fc; end
        sbce_pkg::OpSubR: begin wr_en = 1'b1; wr_data = rb - rc; end
        sbce_pkg::OpCmp: begin
          case (fa[2:0])
            3'd0: flag_nxt = 1'b1;
            3'd1: flag_nxt = 1'b0;
            3'd2: flag_nxt = (x == y);
            3'd3: flag_nxt = (x != y);
            3'd4: flag_nxt = ($signed(x) < $signed(y));
            3'd5: flag_nxt = ($signed(x) > $signed(y));
            3'd6: flag_nxt = (x < y);
            default: flag_nxt = (x > y);
          endcase
        end
        sbce_pkg::OpOrR:  begin wr_en = 1'b1; wr_data = rb | rc; end
        sbce_pkg::OpOrI:  begin wr_en = 1'b1; wr_data = rb | fc; end
        sbce_pkg::OpXorR: begin wr_en = 1'b1; wr_data = rb ^ rc; end
        sbce_pkg::OpXorI: begin wr_en = 1'b1; wr_data = rb ^ fc; end
        sbce_pkg::OpAndR: begin wr_en = 1'b1; wr_data = rb & rc; end
        sbce_pkg::OpAndI: begin wr_en = 1'b1; wr_data = rb & fc; end
        sbce_pkg::OpShImm: begin
          if (fc[5]) st = sbce_pkg::StError;
          else begin wr_en = 1'b1; wr_data = sres; end
        end
        sbce_pkg::OpShlR: begin
          wr_en = 1'b1; wr_data = (rc >= W'(6)) ? '0 : W'(rb << rc[2:0]);
        end
        sbce_pkg::OpShrR: begin
          wr_en = 1'b1; wr_data = (rc >= W'(6)) ? '0 : W'(rb >> rc[2:0]);
        end
        sbce_pkg::OpLoad: begin
          // the first phase reads the word at the load address, the second writes it
          if (!s1_ph_r) ld_wait = 1'b1;
          else begin wr_en = 1'b1; wr_data = va; end
        end
        sbce_pkg::OpStore: begin wr_en = 1'b1; wr_addr = ld_addr; wr_data = ra; end
        sbce_pkg::OpLabel: ;
        sbce_pkg::OpJmpUp, sbce_pkg::OpJmpDn: begin
          st = (op == sbce_pkg::OpJmpUp) ? sbce_pkg::StJmpUp : sbce_pkg::StJmpDn;
          label = {fa, fb};
          key = rc;
        end
        sbce_pkg::OpIo: begin
          if (!dev_ok) st = sbce_pkg::StError;
          else begin
            st = sbce_pkg::StIoReq;
            dev = fb; wdat = rc; dest = fa; wants = dev_rd;
            if (fb == W'(2)) begin wr_en = 1'b1; wr_data = '0; end
          end
        end
        sbce_pkg::OpMul: begin
          wr_en = 1'b1;
          if (fc < W'(sbce_pkg::MulFrac)) wr_data = W'(uprod >> fc[3:0]);
          else wr_data = W'(sprod >>> samt);
        end
        default: st = sbce_pkg::StHalt;
      endcase
    end
    if (wr_addr == '0) wr_en = 1'b0;
  end

  // handshakes
  assign s1_fire = s1_vld_r && !ld_wait && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_fire;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign rd_en = in_acc || (s1_vld_r && ld_wait);

  // read addresses: the load address while a load waits, else from the new word
  always_comb begin
    if (s1_vld_r && ld_wait) begin
      addr_p = ld_addr;
      addr_q = ld_addr;
    end else if ((i_op == sbce_pkg::OpStore) || (i_op == sbce_pkg::OpMul)) begin
      addr_p = in_ch.instr_word[17:12];
      addr_q = in_ch.instr_word[11:6];
    end else begin
      addr_p = in_ch.instr_word[11:6];
      addr_q = in_ch.instr_word[5:0];
    end
  end

  // register file copies, written together
  always_ff @(posedge clk) begin
    if (s1_fire && wr_en) begin
      mem_p_r[wr_addr] <= wr_data;
      mem_q_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_p_r <= mem_p_r[addr_p];
      raw_q_r <= mem_q_r[addr_q];
    end
  end

  // read qualifiers with forwarding of the write at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      zero_p_r <= (addr_p == '0) || !(ent_vld_r[addr_p] || (s1_fire && wr_en && wr_addr == addr_p));
      zero_q_r <= (addr_q == '0) || !(ent_vld_r[addr_q] || (s1_fire && wr_en && wr_addr == addr_q));
      use_p_r  <= s1_fire && wr_en && (wr_addr == addr_p);
      use_q_r  <= s1_fire && wr_en && (wr_addr == addr_q);
      fwd_p_r  <= wr_data;
      fwd_q_r  <= wr_data;
    end
  end

  // pipeline control, flag and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      s1_ph_r   <= 1'b0;
      flag_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_fire && wr_en) ent_vld_r[wr_addr] <= 1'b1;
      if (s1_fire) flag_r <= flag_nxt;
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        s1_ph_r  <= 1'b0;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end else if (s1_vld_r && ld_wait) begin
        s1_ph_r <= 1'b1;
      end
      if (s1_fire) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_ch.kind;
      s1_word_r <= in_ch.instr_word;
      s1_rreg_r <= in_ch.return_reg;
      s1_rdat_r <= in_ch.return_data;
    end
    if (s1_fire) begin
      o_status_r <= st;
      o_flag_r   <= flag_nxt;
      o_label_r  <= label;
      o_key_r    <= key;
      o_dev_r    <= dev;
      o_wdat_r   <= wdat;
      o_dest_r   <= dest;
      o_wants_r  <= wants;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.flag_out      = o_flag_r;
  assign out_ch.jump_label    = o_label_r;
  assign out_ch.jump_key      = o_key_r;
  assign out_ch.io_device     = o_dev_r;
  assign out_ch.io_write_data = o_wdat_r;
  assign out_ch.io_dest_reg   = o_dest_r;
  assign out_ch.io_wants_read = o_wants_r;

endmodule
`default_nettype wire
